@@ rtl/core/cartridge_bank_mapper_macros.svh @@
// ----------------------------------------------------------------------------
// Cartridge bank mapper assertion macros
// Shared shorthand for the concurrent checks in the mapper modules.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cartridge bank mapper: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cartridge bank mapper: next-cycle check failed");

`endif

@@ rtl/core/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Types and constants shared by the mapper modules.
// ----------------------------------------------------------------------------
package cbm_pkg;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_ROM_READ  = 3'd1,
    ACT_RAM_READ  = 3'd2,
    ACT_RAM_WRITE = 3'd3,
    ACT_FIXED     = 3'd4
  } action_t;

  // Address regions, selected by address bits 15:13.
  localparam logic [2:0] RegionRamEnable = 3'b000;
  localparam logic [2:0] RegionRomBank   = 3'b001;
  localparam logic [2:0] RegionRamBank   = 3'b010;
  localparam logic [2:0] RegionExtRam    = 3'b101;

  localparam logic [3:0] RamEnableKey   = 4'hA;
  localparam logic [7:0] RamBankMax     = 8'h03;
  localparam logic [7:0] ClockSelLow    = 8'h08;
  localparam logic [7:0] ClockSelHigh   = 8'h0C;
  localparam logic [7:0] OpenBusData    = 8'hFF;
  localparam logic [7:0] ClockStubData  = 8'h00;
  localparam logic [6:0] RomBankDefault = 7'd1;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    action_t     action;
    logic [20:0] mem_address;
    logic [7:0]  data_out;
  } result_t;

  typedef struct packed {
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic       ram_enabled;
    logic       clock_selected;
  } bank_state_t;

endpackage

@@ rtl/core/cartridge_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank mapper
// Bank controller that turns bus transactions into ROM and RAM requests.
// ----------------------------------------------------------------------------
// The mapper takes one transaction per clock and gives exactly one result per
// transaction: the transaction waits in an input register, is decoded against
// the current bank state, and its result lands in the output register while
// any control write it carries updates the bank state in the same edge.
// Throughput is one transaction per cycle whenever the output side does not
// stall.
`include "cartridge_bank_mapper_macros.svh"

module cartridge_bank_mapper
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [20:0] mem_address,
  output logic [7:0]  data_out
);

  logic        s1_valid;
  req_t        s1_req;
  result_t     out_res;
  result_t     dec_res;
  bank_state_t state;
  logic        out_free;
  logic        advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req.kind       <= kind;
      s1_req.address    <= address;
      s1_req.write_data <= write_data;
    end
  end

  cbm_decode u_decode (
    .req   (s1_req),
    .state (state),
    .res   (dec_res)
  );

  cbm_ctrl_regs u_ctrl_regs (
    .clk    (clk),
    .rst    (rst),
    .update (advance),
    .req    (s1_req),
    .state  (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= dec_res;
    end
  end

  assign action      = out_res.action;
  assign mem_address = out_res.mem_address;
  assign data_out    = out_res.data_out;

  `CBM_ASSERT_NOW(a_stall_needs_item, clk, rst, in_stall, s1_valid && out_valid)
  `CBM_ASSERT_NEXT(a_advance_fills_output, clk, rst, advance, out_valid)
  `CBM_ASSERT_NOW(a_rom_read_no_data, clk, rst, out_valid && (action == ACT_ROM_READ || action == ACT_RAM_READ), data_out == 8'd0)

endmodule

@@ rtl/core/cbm_ctrl_regs.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank mapper control registers
// Holds the bank selects and enable flags and applies control writes.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_macros.svh"

module cbm_ctrl_regs
  import cbm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        update,
  input  req_t        req,
  output bank_state_t state
);

  bank_state_t state_next;

  always_comb begin
    state_next = state;
    if (update && req.kind) begin
      case (req.address[15:13])
        RegionRamEnable: begin
          state_next.ram_enabled = (req.write_data[3:0] == RamEnableKey);
        end
        RegionRomBank: begin
          if (req.write_data[6:0] == 7'd0) begin
            state_next.rom_bank = RomBankDefault;
          end else begin
            state_next.rom_bank = req.write_data[6:0];
          end
        end
        RegionRamBank: begin
          if (req.write_data <= RamBankMax) begin
            state_next.ram_bank       = req.write_data[1:0];
            state_next.clock_selected = 1'b0;
          end else if (req.write_data inside {[ClockSelLow:ClockSelHigh]}) begin
            state_next.clock_selected = 1'b1;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.rom_bank       <= RomBankDefault;
      state.ram_bank       <= 2'd0;
      state.ram_enabled    <= 1'b0;
      state.clock_selected <= 1'b0;
    end else begin
      state <= state_next;
    end
  end

  `CBM_ASSERT_NOW(a_rom_bank_nonzero, clk, rst, 1'b1, state.rom_bank != 7'd0)
  `CBM_ASSERT_NEXT(a_rom_bank_load, clk, rst, update && req.kind && req.address[15:13] == RegionRomBank && req.write_data[6:0] != 7'd0, state.rom_bank == $past(req.write_data[6:0]))
  `CBM_ASSERT_NEXT(a_ram_bank_clears_clock, clk, rst, update && req.kind && req.address[15:13] == RegionRamBank && req.write_data <= RamBankMax, !state.clock_selected && state.ram_bank == $past(req.write_data[1:0]))
  `CBM_ASSERT_NEXT(a_read_keeps_state, clk, rst, update && !req.kind, $stable(state))

endmodule

@@ rtl/core/cbm_decode.sv @@
// ----------------------------------------------------------------------------
// Cartridge bank mapper decoder
// Translates one bus transaction into a memory request using the bank state.
// ----------------------------------------------------------------------------
module cbm_decode
  import cbm_pkg::*;
(
  input  req_t        req,
  input  bank_state_t state,
  output result_t     res
);

  logic        in_ext_ram;
  logic [20:0] ram_address;
  logic [20:0] rom_address;

  assign in_ext_ram  = (req.address[15:13] == RegionExtRam);
  assign ram_address = {6'd0, state.ram_bank, req.address[12:0]};
  assign rom_address = req.address[14] ? {state.rom_bank, req.address[13:0]}
                                       : {7'd0, req.address[13:0]};

  always_comb begin
    res.action      = ACT_NONE;
    res.mem_address = 21'd0;
    res.data_out    = 8'd0;
    if (req.kind) begin
      if (in_ext_ram && state.ram_enabled && !state.clock_selected) begin
        res.action      = ACT_RAM_WRITE;
        res.mem_address = ram_address;
        res.data_out    = req.write_data;
      end
    end else if (!req.address[15]) begin
      res.action      = ACT_ROM_READ;
      res.mem_address = rom_address;
    end else if (in_ext_ram && state.ram_enabled && !state.clock_selected) begin
      res.action      = ACT_RAM_READ;
      res.mem_address = ram_address;
    end else if (in_ext_ram && state.ram_enabled) begin
      res.action   = ACT_FIXED;
      res.data_out = ClockStubData;
    end else begin
      res.action   = ACT_FIXED;
      res.data_out = OpenBusData;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cartridge bank mapper testbench
// Drives bus transactions into the mapper, predicts each memory request from
// a private copy of the bank state and checks every result in order, under
// phases of sender idling, receiver stalling and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import cbm_pkg::*;

  localparam bit KindRead  = 1'b0;
  localparam bit KindWrite = 1'b1;
  localparam int WatchdogLimit = 5000;
  localparam int HoldOffCycles = 200;
  localparam int RandomPerPhase = 250;

  class bank_scoreboard;
    bank_state_t bank;
    result_t     pending_results[$];
    int          mismatches;

    function new();
      bank.rom_bank       = RomBankDefault;
      bank.ram_bank       = 2'd0;
      bank.ram_enabled    = 1'b0;
      bank.clock_selected = 1'b0;
      mismatches          = 0;
    endfunction

    function result_t map_access(logic k, logic [15:0] a, logic [7:0] d);
      result_t r;
      r = '0;
      r.action = ACT_NONE;
      if (k == KindRead) begin
        if (a < 16'h4000) begin
          r.action      = ACT_ROM_READ;
          r.mem_address = {5'd0, a};
        end else if (a < 16'h8000) begin
          r.action      = ACT_ROM_READ;
          r.mem_address = {bank.rom_bank, a[13:0]};
        end else if (a[15:13] == RegionExtRam) begin
          if (!bank.ram_enabled) begin
            r.action   = ACT_FIXED;
            r.data_out = OpenBusData;
          end else if (bank.clock_selected) begin
            r.action   = ACT_FIXED;
            r.data_out = ClockStubData;
          end else begin
            r.action      = ACT_RAM_READ;
            r.mem_address = {6'd0, bank.ram_bank, a[12:0]};
          end
        end else begin
          r.action   = ACT_FIXED;
          r.data_out = OpenBusData;
        end
      end else begin
        if (a[15:13] == RegionRamEnable) begin
          bank.ram_enabled = (d[3:0] == RamEnableKey);
        end else if (a[15:13] == RegionRomBank) begin
          bank.rom_bank = (d[6:0] == 7'd0) ? RomBankDefault : d[6:0];
        end else if (a[15:13] == RegionRamBank) begin
          if (d <= RamBankMax) begin
            bank.ram_bank       = d[1:0];
            bank.clock_selected = 1'b0;
          end else if (d >= ClockSelLow && d <= ClockSelHigh) begin
            bank.clock_selected = 1'b1;
          end
        end else if (a[15:13] == RegionExtRam && bank.ram_enabled &&
                     !bank.clock_selected) begin
          r.action      = ACT_RAM_WRITE;
          r.mem_address = {6'd0, bank.ram_bank, a[12:0]};
          r.data_out    = d;
        end
      end
      return r;
    endfunction

    function void note_access(logic k, logic [15:0] a, logic [7:0] d);
      pending_results.push_back(map_access(k, a, d));
    endfunction

    function void check_result(logic [2:0] act, logic [20:0] addr, logic [7:0] dout);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, action %h, mem_address %h, data_out %h",
                 $time, act, addr, dout);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (act !== want.action) begin
        $display("%0t: action mismatch, expected %h, actual %h", $time, want.action, act);
        mismatches++;
      end
      if (addr !== want.mem_address) begin
        $display("%0t: mem_address mismatch, expected %h, actual %h",
                 $time, want.mem_address, addr);
        mismatches++;
      end
      if (dout !== want.data_out) begin
        $display("%0t: data_out mismatch, expected %h, actual %h", $time, want.data_out, dout);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [15:0] address = 16'd0;
  logic [7:0]  write_data = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [20:0] mem_address;
  logic [7:0]  data_out;

  int          send_idle_pct = 0;
  int          out_stall_pct = 0;
  logic        hold_off_req = 1'b0;
  int          hold_off_left = 0;
  int          quiet_cycles = 0;
  bank_scoreboard sb = new();

  cartridge_bank_mapper dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .address     (address),
    .write_data  (write_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .action      (action),
    .mem_address (mem_address),
    .data_out    (data_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_access(kind, address, write_data);
    end
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(action, mem_address, data_out);
    end
  end

  // The long hold-off is counted here so that the sender keeps offering
  // transactions while the output side is blocked.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_off_left = HoldOffCycles - 1;
      out_stall <= 1'b1;
    end else if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_access(input logic k, input logic [15:0] a, input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    address    <= a;
    write_data <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_access();
    int          sel;
    logic [15:0] a;
    logic [7:0]  d;
    sel = $urandom_range(99);
    a = 16'($urandom);
    d = 8'($urandom);
    if (sel < 10) begin
      if ($urandom_range(1)) d[3:0] = RamEnableKey;
      send_access(KindWrite, 16'($urandom_range(16'h1FFF)), d);
    end else if (sel < 18) begin
      if ($urandom_range(7) == 0) d[6:0] = 7'd0;
      send_access(KindWrite, 16'h2000 + 16'($urandom_range(16'h1FFF)), d);
    end else if (sel < 28) begin
      if ($urandom_range(3) != 0) d = 8'($urandom_range(15));
      send_access(KindWrite, 16'h4000 + 16'($urandom_range(16'h1FFF)), d);
    end else if (sel < 31) begin
      send_access(KindWrite, 16'h6000 + 16'($urandom_range(16'h1FFF)), d);
    end else if (sel < 50) begin
      send_access(KindWrite, 16'hA000 + 16'($urandom_range(16'h1FFF)), d);
    end else if (sel < 70) begin
      send_access(KindRead, 16'hA000 + 16'($urandom_range(16'h1FFF)), d);
    end else if (sel < 85) begin
      send_access(KindRead, 16'($urandom_range(16'h7FFF)), d);
    end else begin
      send_access(1'($urandom_range(1)), a, d);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    for (int i = 0; i < RandomPerPhase; i++) begin
      if (with_hold && i == 60) hold_off_req = 1'b1;
      send_random_access();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_access(KindRead, 16'h0000, 8'h00);
    send_access(KindRead, 16'h3FFF, 8'hFF);
    send_access(KindRead, 16'h4000, 8'h00);
    send_access(KindRead, 16'hA000, 8'h00);
    send_access(KindWrite, 16'hA000, 8'h55);
    send_access(KindWrite, 16'h0000, 8'h0A);
    send_access(KindRead, 16'hBFFF, 8'h00);
    send_access(KindWrite, 16'hA123, 8'h5A);
    send_access(KindWrite, 16'h1FFF, 8'h0B);
    send_access(KindRead, 16'hA000, 8'h00);
    send_access(KindWrite, 16'h1FFF, 8'hFA);
    send_access(KindWrite, 16'h2000, 8'h00);
    send_access(KindRead, 16'h4000, 8'h00);
    send_access(KindWrite, 16'h3FFF, 8'hFF);
    send_access(KindRead, 16'h7FFF, 8'h00);
    send_access(KindWrite, 16'h2ABC, 8'h80);
    send_access(KindWrite, 16'h4000, 8'h03);
    send_access(KindWrite, 16'hBFFF, 8'hFF);
    send_access(KindWrite, 16'h5FFF, 8'h08);
    send_access(KindRead, 16'hA000, 8'h00);
    send_access(KindWrite, 16'h4000, 8'h0D);
    send_access(KindWrite, 16'h4000, 8'h0C);
    send_access(KindWrite, 16'hA000, 8'h12);
    send_access(KindWrite, 16'h6000, 8'h01);
    send_access(KindWrite, 16'h4000, 8'h04);
    send_access(KindWrite, 16'h5000, 8'h02);
    send_access(KindRead, 16'hB000, 8'h00);
    send_access(KindRead, 16'h8000, 8'h00);
    send_access(KindRead, 16'hFFFF, 8'h00);
    send_access(KindWrite, 16'h9FFF, 8'hAA);
    send_access(KindWrite, 16'hC000, 8'h33);

    run_phase(0, 0, 1'b1);
    run_phase(58, 0, 1'b0);
    run_phase(0, 58, 1'b0);
    run_phase(9, 9, 1'b0);
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
